>>> hdl/shape_rasterizer_framebuffer_unit_defines.svh
// ----------------------------------------------------------------------------
// shape rasterizer framebuffer unit assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHAPE_RASTERIZER_FRAMEBUFFER_UNIT_DEFINES_SVH
`define SHAPE_RASTERIZER_FRAMEBUFFER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRFU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define SRFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRFU_ASSERT_ALWAYS(lbl, expr, msg)
`define SRFU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/srfu_pkg.sv
// ----------------------------------------------------------------------------
// srfu_pkg
// shared types and constants of the shape rasterizer framebuffer unit
// ----------------------------------------------------------------------------
`default_nettype none
package srfu_pkg;

    typedef logic signed [11:0] t_coord;

    typedef enum logic [2:0] {
        OP_RING  = 3'd0,
        OP_DISC  = 3'd1,
        OP_FRAME = 3'd2,
        OP_BLOCK = 3'd3,
        OP_LINE  = 3'd4,
        OP_CLEAR = 3'd5,
        OP_READ  = 3'd6,
        OP_NOP   = 3'd7
    } t_op;

    typedef struct packed {
        t_op               op;
        logic signed [9:0] x_a;
        logic signed [9:0] y_a;
        logic signed [9:0] x_b;
        logic signed [9:0] y_b;
        logic [7:0]        radius;
        logic [7:0]        glyph;
    } t_cmd;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    localparam logic [7:0] BLANK_GLYPH = 8'h20;
    localparam logic [17:0] RING_SLACK = 18'd4;

endpackage
`default_nettype wire

>>> hdl/srfu_ram.sv
// ----------------------------------------------------------------------------
// srfu_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module srfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> hdl/srfu_front.sv
// ----------------------------------------------------------------------------
// srfu_front
// takes command words, decodes the request code and queues them
// ----------------------------------------------------------------------------
`default_nettype none
`include "shape_rasterizer_framebuffer_unit_defines.svh"
module srfu_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_valid,
    output logic               o_s_ready,
    input  wire  [55:0]        i_s_data,
    input  wire  [2:0]         i_s_user,
    output logic               o_cmd_valid,
    output srfu_pkg::t_cmd     o_cmd,
    input  wire                i_cmd_pop
);
    import srfu_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int QI_W    = $clog2(Q_DEPTH);

    t_cmd              r_q [Q_DEPTH];
    logic [QI_W-1:0]   r_wp, r_rp;
    logic [QI_W:0]     r_count;
    t_cmd              w_cmd;
    t_op               w_op;
    logic              w_push;

    // every 3-bit request code maps onto one operation, code 7 is the no-op
    assign w_op = t_op'(i_s_user);

    assign w_cmd.op     = w_op;
    assign w_cmd.x_a    = $signed(i_s_data[9:0]);
    assign w_cmd.y_a    = $signed(i_s_data[19:10]);
    assign w_cmd.x_b    = $signed(i_s_data[29:20]);
    assign w_cmd.y_b    = $signed(i_s_data[39:30]);
    assign w_cmd.radius = i_s_data[47:40];
    assign w_cmd.glyph  = i_s_data[55:48];

    assign o_s_ready   = (r_count != (QI_W+1)'(Q_DEPTH));
    assign w_push      = i_s_valid && o_s_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (QI_W+1)'(w_push) - (QI_W+1)'(i_cmd_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    `SRFU_ASSERT_ALWAYS(a_pop_nonempty, !(i_cmd_pop && r_count == '0), "pop from empty queue")
    `SRFU_ASSERT_ALWAYS(a_count_bound, r_count <= (QI_W+1)'(Q_DEPTH), "queue overfilled")
    `SRFU_ASSERT_NEXT(a_push_count, w_push && !i_cmd_pop, r_count == $past(r_count) + 1'b1, "push lost")
endmodule
`default_nettype wire

>>> hdl/srfu_back.sv
// ----------------------------------------------------------------------------
// srfu_back
// walks the pixels of one command and writes them into the framebuffer, or clears it or reads one pixel back
// ----------------------------------------------------------------------------
`default_nettype none
`include "shape_rasterizer_framebuffer_unit_defines.svh"
module srfu_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [8:0]        i_cols,
    input  wire  [8:0]        i_rows,
    input  wire               i_cmd_valid,
    input  wire srfu_pkg::t_cmd i_cmd,
    output logic              o_cmd_pop,
    output logic              o_m_valid,
    input  wire               i_m_ready,
    output logic [7:0]        o_pix,
    output logic              o_rv
);
    import srfu_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** CW);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_BOX, S_HROW, S_VCOL, S_LINE, S_RD, S_RD_DATA, S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    t_coord            r_x, n_x, r_y, n_y;
    t_coord            r_x_lo, n_x_lo, r_x_hi, n_x_hi, r_y_lo, n_y_lo, r_y_hi, n_y_hi;
    logic [15:0]       r_rr, n_rr;
    logic [16:0]       r_dx2, n_dx2, r_dy2, n_dy2, r_dy2_init, n_dy2_init;
    logic signed [23:0] r_err, n_err, r_inc_lo, n_inc_lo, r_inc_hi, n_inc_hi;
    logic              r_sub, n_sub;
    logic              r_from_reset, n_from_reset;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [7:0]        r_res_pix, n_res_pix;
    logic              r_res_rv, n_res_rv;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_pix, n_out_pix;
    logic              r_out_rv, n_out_rv;

    t_coord            w_px, w_py, w_cx, w_cy, w_rise, w_run;
    logic              w_plot, w_we, w_on;
    logic [AW-1:0]     w_addr, w_ram_addr;
    logic [7:0]        w_wdata, w_rdata;
    logic [17:0]       w_d;
    logic signed [9:0] w_k;
    logic signed [19:0] w_k2;
    logic              w_box_hit, w_rd_on;
    t_coord            w_dxo, w_dyo;

    function automatic logic on_canvas(t_coord x, t_coord y, logic [8:0] c, logic [8:0] r);
        on_canvas = !x[11] && !y[11] && (x < $signed({3'b000, c})) && (y < $signed({3'b000, r}));
    endfunction

    function automatic logic [AW-1:0] pix_addr(t_coord x, t_coord y);
        pix_addr = (AW'(y[10:0]) << CW) | AW'(x[10:0]);
    endfunction

    assign w_cx   = t_coord'(r_cmd.x_a);
    assign w_cy   = t_coord'(r_cmd.y_a);
    assign w_rise = t_coord'(r_cmd.y_b) - w_cy;
    assign w_run  = t_coord'(r_cmd.x_b) - w_cx;
    assign w_k    = $signed({2'b00, r_cmd.radius}) - ((r_cmd.op == OP_DISC) ? 10'sd1 : 10'sd0);
    assign w_k2   = w_k * w_k;
    assign w_dxo  = r_x - w_cx;
    assign w_dyo  = r_y - w_cy;
    assign w_d    = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_rd_on = on_canvas(w_cx, w_cy, i_cols, i_rows);

    always_comb begin
        case (r_cmd.op)
            OP_RING: w_box_hit = (w_d + RING_SLACK >= 18'(r_rr)) && (w_d <= 18'(r_rr) + RING_SLACK);
            OP_DISC: w_box_hit = (w_d + RING_SLACK < 18'(r_rr));
            default: w_box_hit = 1'b1;
        endcase
    end

    // pixel produced this cycle
    always_comb begin
        w_px   = r_x;
        w_py   = r_y;
        w_plot = 1'b0;
        case (r_state)
            S_BOX:  w_plot = w_box_hit;
            S_HROW: begin
                w_py   = r_sub ? r_y_hi : r_y_lo;
                w_plot = 1'b1;
            end
            S_VCOL: begin
                w_px   = r_sub ? r_x_hi : r_x_lo;
                w_plot = 1'b1;
            end
            S_LINE: w_plot = 1'b1;
            default: w_plot = 1'b0;
        endcase
    end

    assign w_on   = on_canvas(w_px, w_py, i_cols, i_rows);
    assign w_addr = pix_addr(w_px, w_py);
    assign w_we   = (r_state == S_CLEAR) || (w_plot && w_on);

    always_comb begin
        case (r_state)
            S_CLEAR: w_ram_addr = r_clr_addr;
            S_RD:    w_ram_addr = pix_addr(w_cx, w_cy);
            default: w_ram_addr = w_addr;
        endcase
    end
    assign w_wdata = (r_state == S_CLEAR) ? BLANK_GLYPH : r_cmd.glyph;

    srfu_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_x          = r_x;
        n_y          = r_y;
        n_x_lo       = r_x_lo;
        n_x_hi       = r_x_hi;
        n_y_lo       = r_y_lo;
        n_y_hi       = r_y_hi;
        n_rr         = r_rr;
        n_dx2        = r_dx2;
        n_dy2        = r_dy2;
        n_dy2_init   = r_dy2_init;
        n_err        = r_err;
        n_inc_lo     = r_inc_lo;
        n_inc_hi     = r_inc_hi;
        n_sub        = r_sub;
        n_from_reset = r_from_reset;
        n_clr_addr   = r_clr_addr;
        n_res_pix    = r_res_pix;
        n_res_rv     = r_res_rv;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_pix    = r_out_pix;
        n_out_rv     = r_out_rv;
        o_cmd_pop    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_clr_addr   = '0;
                    n_from_reset = 1'b0;
                    n_state      = r_from_reset ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_res_pix = '0;
                    n_res_rv  = 1'b0;
                    n_state   = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_DONE;
                case (r_cmd.op)
                    OP_RING, OP_DISC: begin
                        n_x        = w_cx - t_coord'(w_k);
                        n_x_hi     = w_cx + t_coord'(w_k);
                        n_y        = w_cy - t_coord'(w_k);
                        n_y_lo     = w_cy - t_coord'(w_k);
                        n_y_hi     = w_cy + t_coord'(w_k);
                        n_rr       = r_cmd.radius * r_cmd.radius;
                        n_dx2      = w_k2[16:0];
                        n_dy2      = w_k2[16:0];
                        n_dy2_init = w_k2[16:0];
                        if (!w_k[9]) begin
                            n_state = S_BOX;
                        end
                    end
                    OP_BLOCK: begin
                        n_x    = w_cx + 12'sd1;
                        n_x_hi = t_coord'(r_cmd.x_b) - 12'sd1;
                        n_y    = w_cy + 12'sd1;
                        n_y_lo = w_cy + 12'sd1;
                        n_y_hi = t_coord'(r_cmd.y_b) - 12'sd1;
                        if ((w_cx + 12'sd1 <= t_coord'(r_cmd.x_b) - 12'sd1) &&
                            (w_cy + 12'sd1 <= t_coord'(r_cmd.y_b) - 12'sd1)) begin
                            n_state = S_BOX;
                        end
                    end
                    OP_FRAME: begin
                        n_x_lo = w_cx;
                        n_x_hi = t_coord'(r_cmd.x_b);
                        n_y_lo = w_cy;
                        n_y_hi = t_coord'(r_cmd.y_b);
                        n_x    = w_cx;
                        n_y    = w_cy + 12'sd1;
                        n_sub  = 1'b0;
                        if (w_cx <= t_coord'(r_cmd.x_b)) begin
                            n_state = S_HROW;
                        end else if (w_cy + 12'sd2 <= t_coord'(r_cmd.y_b)) begin
                            n_state = S_VCOL;
                        end
                    end
                    OP_LINE: begin
                        n_x      = w_cx;
                        n_y      = w_cy;
                        n_x_hi   = t_coord'(r_cmd.x_b);
                        n_err    = (24'(w_rise) <<< 1) - 24'(w_run);
                        n_inc_lo = 24'(w_rise) <<< 1;
                        n_inc_hi = 24'(w_rise - w_run) <<< 1;
                        if (w_run >= 12'sd0) begin
                            n_state = S_LINE;
                        end
                    end
                    OP_CLEAR: begin
                        n_clr_addr = '0;
                        n_state    = S_CLEAR;
                    end
                    OP_READ: begin
                        if (w_rd_on) begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_BOX: begin
                if (r_y == r_y_hi) begin
                    if (r_x == r_x_hi) begin
                        n_state = S_DONE;
                    end else begin
                        n_x   = r_x + 12'sd1;
                        n_y   = r_y_lo;
                        n_dy2 = r_dy2_init;
                        n_dx2 = 17'($signed({2'b00, r_dx2}) + (19'(w_dxo) <<< 1) + 19'sd1);
                    end
                end else begin
                    n_y   = r_y + 12'sd1;
                    n_dy2 = 17'($signed({2'b00, r_dy2}) + (19'(w_dyo) <<< 1) + 19'sd1);
                end
            end
            S_HROW: begin
                n_sub = !r_sub;
                if (r_sub) begin
                    if (r_x == r_x_hi) begin
                        n_y   = r_y_lo + 12'sd1;
                        n_sub = 1'b0;
                        n_state = (r_y_lo + 12'sd2 <= r_y_hi) ? S_VCOL : S_DONE;
                    end else begin
                        n_x = r_x + 12'sd1;
                    end
                end
            end
            S_VCOL: begin
                n_sub = !r_sub;
                if (r_sub) begin
                    if (r_y == r_y_hi - 12'sd1) begin
                        n_state = S_DONE;
                    end else begin
                        n_y = r_y + 12'sd1;
                    end
                end
            end
            S_LINE: begin
                if (r_x == r_x_hi) begin
                    n_state = S_DONE;
                end else begin
                    n_x = r_x + 12'sd1;
                    if (r_err < 24'sd0) begin
                        n_err = r_err + r_inc_lo;
                    end else begin
                        n_err = r_err + r_inc_hi;
                        n_y   = r_y + 12'sd1;
                    end
                end
            end
            S_RD: n_state = S_RD_DATA;
            S_RD_DATA: begin
                n_res_pix = w_rdata;
                n_res_rv  = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_res_pix;
                    n_out_rv    = r_res_rv;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_from_reset <= 1'b1;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_from_reset <= n_from_reset;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_y        <= n_y;
        r_x_lo     <= n_x_lo;
        r_x_hi     <= n_x_hi;
        r_y_lo     <= n_y_lo;
        r_y_hi     <= n_y_hi;
        r_rr       <= n_rr;
        r_dx2      <= n_dx2;
        r_dy2      <= n_dy2;
        r_dy2_init <= n_dy2_init;
        r_err      <= n_err;
        r_inc_lo   <= n_inc_lo;
        r_inc_hi   <= n_inc_hi;
        r_sub      <= n_sub;
        r_res_pix  <= n_res_pix;
        r_res_rv   <= n_res_rv;
        r_out_pix  <= n_out_pix;
        r_out_rv   <= n_out_rv;
    end

    assign o_m_valid = r_out_valid;
    assign o_pix     = r_out_pix;
    assign o_rv      = r_out_rv;

    `SRFU_ASSERT_NEXT(a_pop_to_setup, o_cmd_pop, r_state == S_SETUP, "popped command not taken")
    `SRFU_ASSERT_ALWAYS(a_no_write_idle, !(w_we && (r_state == S_IDLE || r_state == S_RD_DATA)), "stray write")
    `SRFU_ASSERT_NEXT(a_result_loaded, r_state == S_DONE && !r_out_valid, r_out_valid && r_state == S_IDLE, "result lost")
endmodule
`default_nettype wire

>>> hdl/shape_rasterizer_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// shape_rasterizer_framebuffer_unit
// draws circles, rectangles and lines as glyphs into a character framebuffer
// ----------------------------------------------------------------------------
// Every command gives one result word. The drawing engine walks one pixel per
// clock and writes it through the single framebuffer port when it is on the
// canvas and in the shape. It walks (2r+1)^2 pixels for a circle outline,
// (2r-1)^2 for a circle fill, the interior area for a rectangle fill,
// 2*(width) + 2*(height-2) for a rectangle outline and x_b-x_a+1 for a line.
// A read fetches one word, and a clear writes the blank glyph to all
// MAX_HEIGHT * 2^ceil(log2(MAX_WIDTH)) words. After reset the same clearing pass
// runs once (65536 words at the default size) before the first command is taken;
// up to two commands queue at the input meanwhile and the configuration port stays open.
`default_nettype none
module shape_rasterizer_framebuffer_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_a[9:0], y_a[19:10], x_b[29:20], y_b[39:30], radius[47:40], glyph[55:48]
    input  wire  [55:0]                      s_axis_tdata,
    // req_type[2:0]
    input  wire  [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // pixel_value[7:0]
    output logic [7:0]                       m_axis_tdata,
    // read_valid[0]
    output logic                             m_axis_tuser,
    input  wire                              i_cfg_we,
    input  wire  [srfu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [8:0]                       i_cfg_data
);
    import srfu_pkg::*;

    logic [8:0] r_canvas_w, r_canvas_h;
    logic [8:0] w_cols, w_rows;
    logic       w_cmd_valid, w_cmd_pop;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= 9'd256;
            r_canvas_h <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // oversized canvas settings act as the maximum
    assign w_cols = (32'(r_canvas_w) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : r_canvas_w;
    assign w_rows = (32'(r_canvas_h) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_canvas_h;

    srfu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    srfu_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cols      (w_cols),
        .i_rows      (w_rows),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_pix       (m_axis_tdata),
        .o_rv        (m_axis_tuser)
    );
endmodule
`default_nettype wire
